// ----- hdl/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared widths, constants and the coefficient table of the FIR filter with
// block DC offset removal.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

    localparam int TAPS          = 21;
    localparam int TAP_IDX_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SAMPLE_W      = 12;
    localparam int FRAC_BITS     = 8;
    // raw*256 - offset, signed
    localparam int ENTRY_W       = SAMPLE_W + FRAC_BITS + 1;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = ENTRY_W + COEF_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int ACC_FRAC_BITS = 23;
    localparam int OUT_W         = 16;
    localparam int WHOLE_W       = ACC_W - ACC_FRAC_BITS + 2;

    localparam int BLOCK_LEN     = 256;
    localparam int BCOUNT_W      = $clog2(BLOCK_LEN);
    localparam int BSUM_W        = SAMPLE_W + BCOUNT_W;
    localparam int OFFSET_W      = SAMPLE_W + FRAC_BITS;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    typedef struct packed {
        logic clear;   // start of a new request, zero the accumulator
        logic mul_en;  // a tap is presented this cycle
    } mac_ctrl_t;

    // Q1.15 coefficients; taps beyond the table read as zero
    function automatic coef_t coef_at(input logic [TAP_IDX_W-1:0] idx);
        coef_t c;
        case (32'(idx))
            0:       c = -16'sd60;
            1:       c = -16'sd168;
            2:       c = -16'sd272;
            3:       c = -16'sd246;
            4:       c = 16'sd94;
            5:       c = 16'sd728;
            6:       c = 16'sd1466;
            7:       c = 16'sd1947;
            8:       c = 16'sd1784;
            9:       c = 16'sd748;
            10:      c = -16'sd946;
            11:      c = -16'sd2627;
            12:      c = -16'sd3514;
            13:      c = -16'sd3032;
            14:      c = -16'sd1174;
            15:      c = 16'sd1512;
            16:      c = 16'sd3941;
            17:      c = 16'sd4989;
            18:      c = 16'sd3941;
            19:      c = 16'sd1512;
            20:      c = -16'sd1174;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fdc_cell.sv -----
// ----------------------------------------------------------------------------
// fdc_cell
// One delay line entry; takes its neighbor's value when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire fdc_pkg::entry_t    d_in,
    output fdc_pkg::entry_t         d_out
);

    fdc_pkg::entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (en) begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

// ----- hdl/fdc_mac.sv -----
// ----------------------------------------------------------------------------
// fdc_mac
// Multiply-accumulate over the taps presented one per cycle, with final
// truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_mac (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire fdc_pkg::mac_ctrl_t             ctrl,
    input  wire fdc_pkg::entry_t                tap_data,
    input  wire fdc_pkg::coef_t                 coef,
    output logic signed [fdc_pkg::OUT_W-1:0]    result
);

    logic signed [fdc_pkg::PROD_W-1:0]  prod_reg;
    logic                               prod_valid_reg;
    logic signed [fdc_pkg::ACC_W-1:0]   acc_reg;
    logic signed [fdc_pkg::WHOLE_W-1:0] whole;
    logic                               frac_nz;

    always_ff @(posedge aclk) begin
        prod_reg <= fdc_pkg::PROD_W'(tap_data) * fdc_pkg::PROD_W'(coef);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end else begin
            prod_valid_reg <= ctrl.mul_en;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (prod_valid_reg) begin
                acc_reg <= acc_reg + fdc_pkg::ACC_W'(prod_reg);
            end
        end
    end

    // divide by 2^23 toward zero: floor shift, plus one for negative inexact
    assign frac_nz = |acc_reg[fdc_pkg::ACC_FRAC_BITS-1:0];

    always_comb begin
        whole = fdc_pkg::WHOLE_W'(acc_reg >>> fdc_pkg::ACC_FRAC_BITS);
        if (acc_reg[fdc_pkg::ACC_W-1] && frac_nz) begin
            whole = whole + fdc_pkg::WHOLE_W'(1);
        end
        if (whole > fdc_pkg::WHOLE_W'(32767)) begin
            result = 16'sh7FFF;
        end else if (whole < -fdc_pkg::WHOLE_W'(32768)) begin
            result = -16'sh8000;
        end else begin
            result = whole[fdc_pkg::OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fir_filter_block_dc_removal.sv -----
// ----------------------------------------------------------------------------
// fir_filter_block_dc_removal
// 21-tap FIR low-pass on 12-bit converter samples with block DC removal.
//
// Input channel s_*: one unsigned raw sample per request. The current DC
// offset is subtracted and the difference enters a chain of delay cells.
// Output channel m_*: one filtered signed 16-bit sample per request, with
// m_block_done set on the sample that closes a block of 256; from the next
// sample on, the offset is the mean of that block.
// Each request takes in the input sample, then the chain rotates once per
// cycle past a single multiply-accumulate unit, one tap a cycle, then the
// last accumulate is done and the output register is loaded. s_ready is high
// only while no sample is in work.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls longer, the finished sum holds until the
// output register frees up.
// Reset (aresetn, synchronous, active low) zeroes the delay line, offset and
// block counters and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_block_dc_removal (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [fdc_pkg::SAMPLE_W-1:0]       s_raw_sample,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fdc_pkg::OUT_W-1:0]        m_filtered_sample,
    output logic                                    m_block_done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [fdc_pkg::TAP_IDX_W-1:0]      tap_cnt_reg;
    logic [fdc_pkg::OFFSET_W-1:0]       offset_reg;
    logic [fdc_pkg::BSUM_W-1:0]         bsum_reg;
    logic [fdc_pkg::BCOUNT_W-1:0]       bcount_reg;
    logic                               done_pend_reg;
    logic                               m_valid_reg;
    logic signed [fdc_pkg::OUT_W-1:0]   filt_reg;
    logic                               done_out_reg;

    logic                               accept;
    logic                               rotate;
    logic                               out_load;
    logic                               block_end;
    logic [fdc_pkg::BSUM_W-1:0]         bsum_next;
    fdc_pkg::entry_t                    new_entry;
    fdc_pkg::entry_t                    cell_q [fdc_pkg::TAPS];
    fdc_pkg::entry_t                    cell_d [fdc_pkg::TAPS];
    fdc_pkg::mac_ctrl_t                 mac_ctrl;
    logic signed [fdc_pkg::OUT_W-1:0]   mac_result;
    logic [fdc_pkg::TAP_IDX_W-1:0]      coef_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign rotate   = (state_reg == ST_MAC);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign new_entry = $signed({1'b0, s_raw_sample, fdc_pkg::FRAC_BITS'(0)})
                     - $signed({1'b0, offset_reg});

    // cell 0 takes the new entry on a request, the last cell while rotating
    assign cell_d[0] = rotate ? cell_q[fdc_pkg::TAPS-1] : new_entry;

    for (genvar i = 0; i < fdc_pkg::TAPS; i++) begin : g_cell
        if (i > 0) begin : g_link
            assign cell_d[i] = cell_q[i-1];
        end
        fdc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (accept || rotate),
            .d_in    (cell_d[i]),
            .d_out   (cell_q[i])
        );
    end

    // after k rotations the last cell holds tap TAPS-1-k
    assign coef_idx = fdc_pkg::TAP_IDX_W'(fdc_pkg::TAPS - 1) - tap_cnt_reg;

    assign mac_ctrl.clear  = accept;
    assign mac_ctrl.mul_en = rotate;

    fdc_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .tap_data (cell_q[fdc_pkg::TAPS-1]),
        .coef     (fdc_pkg::coef_at(coef_idx)),
        .result   (mac_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (tap_cnt_reg == fdc_pkg::TAP_IDX_W'(fdc_pkg::TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign block_end = (bcount_reg == fdc_pkg::BCOUNT_W'(fdc_pkg::BLOCK_LEN - 1));
    assign bsum_next = bsum_reg + fdc_pkg::BSUM_W'(s_raw_sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_cnt_reg   <= '0;
            offset_reg    <= '0;
            bsum_reg      <= '0;
            bcount_reg    <= '0;
            done_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                tap_cnt_reg   <= '0;
                done_pend_reg <= block_end;
                if (block_end) begin
                    offset_reg <= fdc_pkg::OFFSET_W'(
                        {bsum_next, fdc_pkg::FRAC_BITS'(0)} / fdc_pkg::BLOCK_LEN);
                    bsum_reg   <= '0;
                    bcount_reg <= '0;
                end else begin
                    bsum_reg   <= bsum_next;
                    bcount_reg <= bcount_reg + fdc_pkg::BCOUNT_W'(1);
                end
            end else if (rotate) begin
                tap_cnt_reg <= tap_cnt_reg + fdc_pkg::TAP_IDX_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            filt_reg     <= mac_result;
            done_out_reg <= done_pend_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = filt_reg;
    assign m_block_done      = done_out_reg;

endmodule

`default_nettype wire
